[sv/fe_pkg.sv]
package fe_pkg;

    localparam int MAX_ITER_DEF = 32;
    localparam int QDEPTH       = 2;

    localparam logic signed [63:0] SAT_LIM = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] Q28_ONE = 64'sd268435456;
    localparam logic signed [31:0] PI_Q28  = 32'sd843314857;
    localparam logic signed [31:0] HPI_Q28 = 32'sd421657428;
    localparam logic signed [63:0] TOL_Q28 = 64'sd256;
    localparam logic [31:0]        FOCAL_MIN = 32'd65536;

    localparam int CORDIC_STEPS = 30;

    localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
        32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
        32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
        32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
        32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002
    };

    typedef enum logic [2:0] {
        REG_FOCAL_X  = 3'd0,
        REG_FOCAL_Y  = 3'd1,
        REG_CENTER_X = 3'd2,
        REG_CENTER_Y = 3'd3,
        REG_DIST_K1  = 3'd4,
        REG_DIST_K2  = 3'd5,
        REG_DIST_K3  = 3'd6,
        REG_DIST_K4  = 3'd7
    } reg_index_t;

    typedef struct packed {
        logic [31:0]        focal_x;
        logic [31:0]        focal_y;
        logic [30:0]        center_x;
        logic [30:0]        center_y;
        logic signed [31:0] dist_k1;
        logic signed [31:0] dist_k2;
        logic signed [31:0] dist_k3;
        logic signed [31:0] dist_k4;
    } cfg_t;

    typedef struct packed {
        logic               norm;
        logic signed [63:0] x;
        logic signed [63:0] y;
    } q_item_t;

    typedef struct packed {
        logic               go;
        logic signed [63:0] a;
        logic signed [63:0] b;
    } mul_req_t;

    typedef struct packed {
        logic        go;
        logic [62:0] n;
        logic [63:0] d;
    } div_req_t;

    function automatic logic signed [63:0] sat62(input logic signed [63:0] v);
        logic signed [63:0] r;
        r = v;
        if (v > SAT_LIM)
        begin
            r = SAT_LIM;
        end
        else if (v < -SAT_LIM)
        begin
            r = -SAT_LIM;
        end
        return r;
    endfunction

    function automatic logic [62:0] mag63(input logic signed [63:0] v);
        logic signed [63:0] n;
        n = -v;
        return v[63] ? n[62:0] : v[62:0];
    endfunction

endpackage

[sv/fe_front.sv]
module fe_front
    import fe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,
    input  logic        s_axis_tuser,
    output logic        q_valid,
    input  logic        q_ready,
    output q_item_t     q_item
);

    localparam int PW = $clog2(QDEPTH);

    q_item_t            mem [QDEPTH];
    logic [PW-1:0]      wr_ptr_reg;
    logic [PW-1:0]      rd_ptr_reg;
    logic [PW:0]        count_reg;
    logic               push;
    logic               pop;
    q_item_t            item_in;
    logic signed [31:0] cx;
    logic signed [31:0] cy;

    assign cx = s_axis_tdata[31:0];
    assign cy = s_axis_tdata[63:32];

    // pixel mode keeps the offset from the principal point, the division follows in the back
    always_comb
    begin
        item_in.norm = s_axis_tuser;
        if (s_axis_tuser)
        begin
            item_in.x = {{20{cx[31]}}, cx, 12'b0};
            item_in.y = {{20{cy[31]}}, cy, 12'b0};
        end
        else
        begin
            item_in.x = $signed({{32{cx[31]}}, cx}) - $signed({33'b0, cfg.center_x});
            item_in.y = $signed({{32{cy[31]}}, cy}) - $signed({33'b0, cfg.center_y});
        end
    end

    assign s_axis_tready = (count_reg < (PW+1)'(QDEPTH));
    assign q_valid       = (count_reg != '0);
    assign q_item        = mem[rd_ptr_reg];
    assign push          = s_axis_tvalid && s_axis_tready;
    assign pop           = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= item_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QDEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QDEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[sv/fe_mul.sv]
module fe_mul
    import fe_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  mul_req_t           req,
    output logic               done,
    output logic signed [63:0] res
);

    logic               busy_reg;
    logic               done_reg;
    logic [1:0]         cnt_reg;
    logic               neg_reg;
    logic [61:0]        ua_reg;
    logic [61:0]        ub_reg;
    logic [123:0]       acc_reg;
    logic [30:0]        pa;
    logic [30:0]        pb;
    logic [61:0]        pp;
    logic [123:0]       pp_sh;
    logic [61:0]        m62;
    logic signed [63:0] m64;
    logic signed [63:0] ma;
    logic signed [63:0] mb;

    assign ma = req.a[63] ? -req.a : req.a;
    assign mb = req.b[63] ? -req.b : req.b;

    // four 31x31 partial products, one per cycle
    always_comb
    begin
        pa    = (cnt_reg[1]) ? ua_reg[61:31] : ua_reg[30:0];
        pb    = (cnt_reg == 2'd1 || cnt_reg == 2'd3) ? ub_reg[61:31] : ub_reg[30:0];
        pp    = 62'(pa) * 62'(pb);
        unique case (cnt_reg)
            2'd0:    pp_sh = {62'b0, pp};
            2'd1:    pp_sh = {31'b0, pp, 31'b0};
            2'd2:    pp_sh = {31'b0, pp, 31'b0};
            default: pp_sh = {pp, 62'b0};
        endcase
    end

    assign m62  = (|acc_reg[123:90]) ? SAT_LIM[61:0] : acc_reg[89:28];
    assign m64  = {2'b0, m62};
    assign res  = neg_reg ? -m64 : m64;
    assign done = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            neg_reg  <= 1'b0;
            ua_reg   <= '0;
            ub_reg   <= '0;
            acc_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.go)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                neg_reg  <= req.a[63] ^ req.b[63];
                ua_reg   <= ma[61:0];
                ub_reg   <= mb[61:0];
                acc_reg  <= '0;
            end
            else if (busy_reg)
            begin
                acc_reg <= acc_reg + pp_sh;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == 2'd3)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

[sv/fe_div.sv]
module fe_div
    import fe_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  div_req_t           req,
    output logic               done,
    output logic signed [63:0] res
);

    localparam int NW = 63 + 28;
    localparam int CW = $clog2(NW);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [NW-1:0] num_reg;
    logic [NW-1:0] q_reg;
    logic [63:0]   rem_reg;
    logic [63:0]   den_reg;
    logic [63:0]   rem_sh;
    logic          fits;

    // restoring division of n * 2^28 by d, one quotient bit per cycle
    assign rem_sh = {rem_reg[62:0], num_reg[NW-1]};
    assign fits   = (rem_sh >= den_reg);
    assign res    = (|q_reg[NW-1:62]) ? SAT_LIM : {2'b0, q_reg[61:0]};
    assign done   = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            num_reg  <= '0;
            q_reg    <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.go)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                num_reg  <= {req.n, 28'b0};
                q_reg    <= '0;
                rem_reg  <= '0;
                den_reg  <= req.d;
            end
            else if (busy_reg)
            begin
                rem_reg <= fits ? rem_sh - den_reg : rem_sh;
                q_reg   <= {q_reg[NW-2:0], fits};
                num_reg <= {num_reg[NW-2:0], 1'b0};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(NW-1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

[sv/fe_back.sv]
module fe_back
    import fe_pkg::*;
#(
    parameter int MAX_ITERATIONS = MAX_ITER_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        q_valid,
    output logic        q_ready,
    input  q_item_t     q_item,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,
    output logic        m_axis_tuser
);

    localparam int IW = $clog2(MAX_ITERATIONS + 1);
    localparam logic [3:0] MS_U    = 4'd0;
    localparam logic [3:0] MS_F    = 4'd5;
    localparam logic [3:0] MS_LAST = 4'd9;

    typedef enum logic [4:0] {
        S_IDLE, S_NXW, S_NYW, S_CLASS, S_DBL, S_CORDIC, S_PHI, S_SHIFT,
        S_SQ0, S_SQ1, S_SQRT, S_MSTART, S_MWAIT, S_DCHK, S_DWAIT, S_CHECK, S_FIN
    } state_t;

    state_t             state_reg;
    mul_req_t           mul_req_reg;
    div_req_t           div_req_reg;
    logic               mul_done;
    logic               div_done;
    logic signed [63:0] mul_res;
    logic signed [63:0] div_res;

    logic signed [63:0] xv_reg, yv_reg, xn_reg, yn_reg;
    logic signed [63:0] cx_reg, cy_reg;
    logic [63:0]        shx_reg, shy_reg;
    logic [4:0]         s_reg;
    logic [4:0]         i_reg;
    logic signed [33:0] z_reg;
    logic [63:0]        sum_reg, v_reg, res_reg, sqb_reg;
    logic signed [63:0] r_reg, th_reg, u_reg, p_reg, d_reg, f_reg, nx_reg;
    logic [3:0]         mstep_reg;
    logic [IW-1:0]      iter_reg;
    logic signed [31:0] theta_reg, phi_reg;
    logic               ok_reg;
    logic               out_valid_reg;
    logic [63:0]        out_data_reg;
    logic               out_user_reg;

    logic [63:0]        fx_eff, fy_eff;
    logic signed [63:0] k1e, k2e, k3e, k4e;
    logic signed [63:0] kadd, dadd;
    logic signed [63:0] mul_a, mul_b;
    logic signed [63:0] absx, absy;
    logic signed [63:0] xsh, ysh;
    logic signed [33:0] tab_z;
    logic signed [33:0] zr;
    logic signed [31:0] a32;
    logic [63:0]        sq_t, sq_v_next, sq_res_next;
    logic signed [63:0] qs;
    logic signed [63:0] dlt;
    logic signed [63:0] dmag;

    assign fx_eff = {32'b0, (cfg.focal_x < FOCAL_MIN) ? FOCAL_MIN : cfg.focal_x};
    assign fy_eff = {32'b0, (cfg.focal_y < FOCAL_MIN) ? FOCAL_MIN : cfg.focal_y};
    assign k1e    = 64'(cfg.dist_k1);
    assign k2e    = 64'(cfg.dist_k2);
    assign k3e    = 64'(cfg.dist_k3);
    assign k4e    = 64'(cfg.dist_k4);
    assign absx   = xn_reg[63] ? -xn_reg : xn_reg;
    assign absy   = yn_reg[63] ? -yn_reg : yn_reg;
    assign xsh    = cx_reg >>> i_reg;
    assign ysh    = cy_reg >>> i_reg;
    assign tab_z  = $signed({2'b0, ATAN_TAB[i_reg]});
    assign zr     = (z_reg + 34'sd2) >>> 2;
    assign a32    = zr[31:0];
    assign qs     = (f_reg[63] ^ d_reg[63]) ? -div_res : div_res;
    assign dlt    = nx_reg - th_reg;
    assign dmag   = d_reg[63] ? -d_reg : d_reg;

    // polynomial and derivative coefficients, Horner order
    always_comb
    begin
        unique case (mstep_reg)
            4'd1:    kadd = k3e;
            4'd2:    kadd = k2e;
            4'd3:    kadd = k1e;
            default: kadd = Q28_ONE;
        endcase
        unique case (mstep_reg)
            4'd6:    dadd = (k3e <<< 3) - k3e;
            4'd7:    dadd = (k2e <<< 2) + k2e;
            4'd8:    dadd = (k1e <<< 1) + k1e;
            default: dadd = Q28_ONE;
        endcase
        mul_a = (mstep_reg == MS_U || mstep_reg == MS_F) ? th_reg : u_reg;
        if (mstep_reg == MS_U)
        begin
            mul_b = th_reg;
        end
        else if (mstep_reg <= MS_F)
        begin
            mul_b = p_reg;
        end
        else
        begin
            mul_b = d_reg;
        end
    end

    always_comb
    begin
        sq_t = res_reg + sqb_reg;
        if (v_reg >= sq_t)
        begin
            sq_v_next   = v_reg - sq_t;
            sq_res_next = (res_reg >> 1) + sqb_reg;
        end
        else
        begin
            sq_v_next   = v_reg;
            sq_res_next = res_reg >> 1;
        end
    end

    fe_mul u_mul
    (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (mul_req_reg),
        .done (mul_done),
        .res  (mul_res)
    );

    fe_div u_div
    (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (div_req_reg),
        .done (div_done),
        .res  (div_res)
    );

    assign q_ready       = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mul_req_reg   <= '0;
            div_req_reg   <= '0;
            xv_reg        <= '0;
            yv_reg        <= '0;
            xn_reg        <= '0;
            yn_reg        <= '0;
            cx_reg        <= '0;
            cy_reg        <= '0;
            shx_reg       <= '0;
            shy_reg       <= '0;
            s_reg         <= '0;
            i_reg         <= '0;
            z_reg         <= '0;
            sum_reg       <= '0;
            v_reg         <= '0;
            res_reg       <= '0;
            sqb_reg       <= '0;
            r_reg         <= '0;
            th_reg        <= '0;
            u_reg         <= '0;
            p_reg         <= '0;
            d_reg         <= '0;
            f_reg         <= '0;
            nx_reg        <= '0;
            mstep_reg     <= '0;
            iter_reg      <= '0;
            theta_reg     <= '0;
            phi_reg       <= '0;
            ok_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_user_reg  <= 1'b0;
        end
        else
        begin
            mul_req_reg.go <= 1'b0;
            div_req_reg.go <= 1'b0;
            if (out_valid_reg && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        xv_reg <= q_item.x;
                        yv_reg <= q_item.y;
                        if (q_item.norm)
                        begin
                            xn_reg    <= q_item.x;
                            yn_reg    <= q_item.y;
                            state_reg <= S_CLASS;
                        end
                        else
                        begin
                            div_req_reg <= '{go: 1'b1, n: mag63(q_item.x), d: fx_eff};
                            state_reg   <= S_NXW;
                        end
                    end
                end
                S_NXW:
                begin
                    if (div_done)
                    begin
                        xn_reg      <= xv_reg[63] ? -div_res : div_res;
                        div_req_reg <= '{go: 1'b1, n: mag63(yv_reg), d: fy_eff};
                        state_reg   <= S_NYW;
                    end
                end
                S_NYW:
                begin
                    if (div_done)
                    begin
                        yn_reg    <= yv_reg[63] ? -div_res : div_res;
                        state_reg <= S_CLASS;
                    end
                end
                S_CLASS:
                begin
                    shx_reg <= absx;
                    shy_reg <= absy;
                    s_reg   <= '0;
                    if (xn_reg == '0 && yn_reg == '0)
                    begin
                        theta_reg <= '0;
                        phi_reg   <= '0;
                        ok_reg    <= 1'b1;
                        state_reg <= S_FIN;
                    end
                    else if (xn_reg == '0)
                    begin
                        phi_reg   <= yn_reg[63] ? -HPI_Q28 : HPI_Q28;
                        state_reg <= S_SHIFT;
                    end
                    else if (yn_reg == '0)
                    begin
                        phi_reg   <= xn_reg[63] ? PI_Q28 : '0;
                        state_reg <= S_SHIFT;
                    end
                    else
                    begin
                        cx_reg    <= absx;
                        cy_reg    <= absy;
                        state_reg <= S_DBL;
                    end
                end
                S_DBL:
                begin
                    if (cx_reg < (64'sd1 <<< 40) && cy_reg < (64'sd1 <<< 40))
                    begin
                        cx_reg <= cx_reg <<< 1;
                        cy_reg <= cy_reg <<< 1;
                    end
                    else
                    begin
                        i_reg     <= '0;
                        z_reg     <= '0;
                        state_reg <= S_CORDIC;
                    end
                end
                S_CORDIC:
                begin
                    if (!cy_reg[63])
                    begin
                        cx_reg <= cx_reg + ysh;
                        cy_reg <= cy_reg - xsh;
                        z_reg  <= z_reg + tab_z;
                    end
                    else
                    begin
                        cx_reg <= cx_reg - ysh;
                        cy_reg <= cy_reg + xsh;
                        z_reg  <= z_reg - tab_z;
                    end
                    i_reg <= i_reg + 1'b1;
                    if (i_reg == 5'(CORDIC_STEPS-1))
                    begin
                        state_reg <= S_PHI;
                    end
                end
                S_PHI:
                begin
                    if (!xn_reg[63])
                    begin
                        phi_reg <= yn_reg[63] ? -a32 : a32;
                    end
                    else
                    begin
                        phi_reg <= yn_reg[63] ? PI_Q28 + a32 : PI_Q28 - a32;
                    end
                    state_reg <= S_SHIFT;
                end
                S_SHIFT:
                begin
                    if (|(shx_reg[63:31] | shy_reg[63:31]))
                    begin
                        shx_reg <= shx_reg >> 1;
                        shy_reg <= shy_reg >> 1;
                        s_reg   <= s_reg + 1'b1;
                    end
                    else
                    begin
                        state_reg <= S_SQ0;
                    end
                end
                S_SQ0:
                begin
                    sum_reg   <= 64'(shx_reg[30:0]) * 64'(shx_reg[30:0]);
                    state_reg <= S_SQ1;
                end
                S_SQ1:
                begin
                    v_reg     <= sum_reg + 64'(shy_reg[30:0]) * 64'(shy_reg[30:0]);
                    res_reg   <= '0;
                    sqb_reg   <= 64'd1 << 62;
                    i_reg     <= '0;
                    state_reg <= S_SQRT;
                end
                S_SQRT:
                begin
                    v_reg   <= sq_v_next;
                    res_reg <= sq_res_next;
                    sqb_reg <= sqb_reg >> 2;
                    i_reg   <= i_reg + 1'b1;
                    if (i_reg == 5'd31)
                    begin
                        r_reg     <= $signed(sq_res_next << s_reg);
                        th_reg    <= Q28_ONE;
                        iter_reg  <= '0;
                        mstep_reg <= MS_U;
                        state_reg <= S_MSTART;
                    end
                end
                S_MSTART:
                begin
                    mul_req_reg <= '{go: 1'b1, a: mul_a, b: mul_b};
                    state_reg   <= S_MWAIT;
                end
                S_MWAIT:
                begin
                    if (mul_done)
                    begin
                        if (mstep_reg == MS_U)
                        begin
                            u_reg <= mul_res;
                            p_reg <= k4e;
                        end
                        else if (mstep_reg < MS_F)
                        begin
                            p_reg <= sat62(mul_res + kadd);
                        end
                        else if (mstep_reg == MS_F)
                        begin
                            f_reg <= sat62(mul_res - r_reg);
                            d_reg <= (k4e <<< 3) + k4e;
                        end
                        else
                        begin
                            d_reg <= sat62(mul_res + dadd);
                        end
                        if (mstep_reg == MS_LAST)
                        begin
                            state_reg <= S_DCHK;
                        end
                        else
                        begin
                            mstep_reg <= mstep_reg + 1'b1;
                            state_reg <= S_MSTART;
                        end
                    end
                end
                S_DCHK:
                begin
                    if (d_reg == '0)
                    begin
                        theta_reg <= '0;
                        ok_reg    <= 1'b0;
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        div_req_reg <= '{go: 1'b1, n: mag63(f_reg), d: dmag};
                        state_reg   <= S_DWAIT;
                    end
                end
                S_DWAIT:
                begin
                    if (div_done)
                    begin
                        nx_reg    <= sat62(th_reg - qs);
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    if (dlt < TOL_Q28 && dlt > -TOL_Q28)
                    begin
                        if (nx_reg[63:31] == '0 || nx_reg[63:31] == '1)
                        begin
                            theta_reg <= nx_reg[31:0];
                            ok_reg    <= 1'b1;
                        end
                        else
                        begin
                            theta_reg <= '0;
                            ok_reg    <= 1'b0;
                        end
                        state_reg <= S_FIN;
                    end
                    else if (iter_reg == IW'(MAX_ITERATIONS-1))
                    begin
                        theta_reg <= '0;
                        ok_reg    <= 1'b0;
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        th_reg    <= nx_reg;
                        iter_reg  <= iter_reg + 1'b1;
                        mstep_reg <= MS_U;
                        state_reg <= S_MSTART;
                    end
                end
                S_FIN:
                begin
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {phi_reg, theta_reg};
                        out_user_reg  <= ok_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[sv/fisheye_unprojection.sv]
// Fisheye unprojection: each input point (pixel or normalized lens units) yields one result
// with the incidence angle theta, the azimuth phi and a converged flag. Points are queued
// two deep at the input, so the stream keeps flowing while one point is being solved, until
// the queue is full. Before the Newton loop a point goes through two divisions (pixel mode
// only), operand scaling plus 30 CORDIC steps, a range shift and a square root; a point on
// an axis skips the operand scaling and the CORDIC steps, and the origin goes straight to
// the result. Each Newton step makes ten passes through the shared 31x31 multiplier and one
// pass through the bit-serial divider. Newton stops after MAX_ITERATIONS steps at most.
// Configuration writes are accepted in every cycle and must only be issued while idle.
module fisheye_unprojection
    import fe_pkg::*;
#(
    parameter int MAX_ITERATIONS = MAX_ITER_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // coord_x, coord_y
    input  logic        s_axis_tuser,   // is_normalized
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // theta, phi
    output logic        m_axis_tuser,   // converged
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    cfg_t    cfg_reg;
    logic    q_valid;
    logic    q_ready;
    q_item_t q_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg          <= '0;
            cfg_reg.focal_x  <= FOCAL_MIN;
            cfg_reg.focal_y  <= FOCAL_MIN;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_FOCAL_X:  cfg_reg.focal_x  <= cfg_data;
                REG_FOCAL_Y:  cfg_reg.focal_y  <= cfg_data;
                REG_CENTER_X: cfg_reg.center_x <= cfg_data[30:0];
                REG_CENTER_Y: cfg_reg.center_y <= cfg_data[30:0];
                REG_DIST_K1:  cfg_reg.dist_k1  <= cfg_data;
                REG_DIST_K2:  cfg_reg.dist_k2  <= cfg_data;
                REG_DIST_K3:  cfg_reg.dist_k3  <= cfg_data;
                REG_DIST_K4:  cfg_reg.dist_k4  <= cfg_data;
                default:      cfg_reg          <= cfg_reg;
            endcase
        end
    end

    fe_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_item       (q_item)
    );

    fe_back #(
        .MAX_ITERATIONS(MAX_ITERATIONS)
    ) u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_item       (q_item),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

endmodule

[sv/fe_checker.sv]
module fe_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        cfg_valid,
    input logic        cfg_ready
);

    // stalled result transaction stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped or changed while stalled");

    // no convergence means theta reads zero
    a_theta_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[31:0] == 32'd0)
        else $error("theta not zero on unconverged result");

    // azimuth stays within -pi/2 .. 3pi/2 plus a small margin
    a_phi_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[63:32]) >= -32'sd438434644)
                       && ($signed(m_axis_tdata[63:32]) <= 32'sd1281749501))
        else $error("phi out of range");

    // configuration port never stalls
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration transaction stalled");

endmodule

bind fisheye_unprojection fe_checker u_checker (.*);
